// ===== rtl/bspe_pkg.sv =====
// Shared constants, codes and controller command type for the bit stream packer.
package bspe_pkg;

  // Word geometry (fixed)
  localparam int WORD_BITS    = 32;
  localparam int OFF_W        = 5;
  localparam int CNT_W        = 6;
  localparam int POS_W        = 15;
  localparam int LEN_W        = 16;
  localparam int STAT_W       = 2;

  // Default store size in words
  localparam int STORE_WORDS  = 1024;

  // Item operation
  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // Result status
  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_WIDE = 2'd1,
    STAT_FULL = 2'd2
  } stat_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming word
    logic fetch;   // read both store banks
    logic finish;  // compute, write back, load the result register
  } cmd_t;

endpackage

// ===== rtl/bspe_ctrl.sv =====
// Sequencing state machine and handshake control for the bit stream packer.
module bspe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bspe_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_WRITE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   finish;
  logic   in_take;

  // Result slot is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == S_WRITE) && out_free;
  assign in_stall_o = !((state_q == S_IDLE) || finish);
  assign in_take    = in_valid_i && !in_stall_o;

  // Next state and result valid
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_take) state_d = S_FETCH;
      end
      S_FETCH: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (finish) state_d = in_take ? S_FETCH : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.load    = in_take;
  assign cmd_o.fetch   = (state_q == S_FETCH);
  assign cmd_o.finish  = finish;

endmodule

// ===== rtl/bspe_dp.sv =====
// Datapath: item latch, bit cursor, two-bank word store, pack and extract logic.
module bspe_dp #(
  parameter int STORE_WORDS = bspe_pkg::STORE_WORDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bspe_pkg::cmd_t              cmd_i,
  input  logic                        op_i,
  input  logic [31:0]                 value_i,
  input  logic [bspe_pkg::CNT_W-1:0]  bit_count_i,
  input  logic [bspe_pkg::POS_W-1:0]  position_i,
  output logic [31:0]                 read_data_o,
  output logic [bspe_pkg::LEN_W-1:0]  stream_length_o,
  output logic [bspe_pkg::STAT_W-1:0] status_o
);

  localparam int BANK_DEPTH = (STORE_WORDS + 1) / 2;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CUR_W      = $clog2(STORE_WORDS * bspe_pkg::WORD_BITS + 1);
  localparam int IDX_RAW    = (CUR_W - bspe_pkg::OFF_W > bspe_pkg::POS_W - bspe_pkg::OFF_W) ?
                              CUR_W - bspe_pkg::OFF_W : bspe_pkg::POS_W - bspe_pkg::OFF_W;
  localparam int WI_W       = IDX_RAW + 1;
  localparam int SW         = WI_W + bspe_pkg::OFF_W;
  localparam int STORE_BITS = STORE_WORDS * bspe_pkg::WORD_BITS;

  // Item latch
  bspe_pkg::op_e              op_q;
  logic [31:0]                value_q;
  logic [bspe_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [bspe_pkg::POS_W-1:0] pos_q;

  // Bit cursor
  logic [CUR_W-1:0] cursor_q, cursor_d;

  // Store banks: even words and odd words
  logic [31:0] mem_even [BANK_DEPTH];
  logic [31:0] mem_odd  [BANK_DEPTH];
  logic [31:0] even_rd_q, odd_rd_q;

  // Result register
  logic [31:0]                 read_data_q, read_data_d;
  logic [bspe_pkg::LEN_W-1:0]  length_q, length_d;
  bspe_pkg::stat_e             status_q, status_d;

  logic [WI_W-1:0]  word0, word1;
  logic [bspe_pkg::OFF_W-1:0] off;
  logic [BA_W-1:0]  even_addr, odd_addr;
  logic [31:0]      w0, w1, r0, r1, old_word;
  logic [63:0]      win, placed;
  logic [31:0]      win_hi;
  logic [6:0]       place_sh;
  logic [5:0]       read_sh;
  logic             w1_ok, do_app;
  logic             we_even, we_odd;
  logic [31:0]      even_wdata, odd_wdata;
  logic [SW-1:0]    cur_ext, cur_new;

  // Saturate the count at one word
  assign cnt_d = (bit_count_i > bspe_pkg::CNT_W'(bspe_pkg::WORD_BITS)) ?
                 bspe_pkg::CNT_W'(bspe_pkg::WORD_BITS) : bit_count_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= bspe_pkg::op_e'(op_i);
      value_q <= value_i;
      cnt_q   <= cnt_d;
      pos_q   <= position_i;
    end
  end

  // First word and offset: cursor for append, position for read
  always_comb begin
    if (op_q == bspe_pkg::OP_READ) begin
      word0 = WI_W'(pos_q[bspe_pkg::POS_W-1:bspe_pkg::OFF_W]);
      off   = pos_q[bspe_pkg::OFF_W-1:0];
    end else begin
      word0 = WI_W'(cursor_q[CUR_W-1:bspe_pkg::OFF_W]);
      off   = cursor_q[bspe_pkg::OFF_W-1:0];
    end
    word1 = word0 + WI_W'(1);
  end

  // Adjacent words always fall in different banks
  assign even_addr = word0[0] ? word1[BA_W:1] : word0[BA_W:1];
  assign odd_addr  = word0[BA_W:1];

  // Bank reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      even_rd_q <= mem_even[even_addr];
      odd_rd_q  <= mem_odd[odd_addr];
    end
  end

  assign w0 = word0[0] ? odd_rd_q  : even_rd_q;
  assign w1 = word0[0] ? even_rd_q : odd_rd_q;

  // Words at or past the cursor hold nothing yet
  assign cur_ext = SW'(cursor_q);
  assign r0 = ({word0, {bspe_pkg::OFF_W{1'b0}}} < cur_ext) ? w0 : 32'd0;
  assign r1 = ({word1, {bspe_pkg::OFF_W{1'b0}}} < cur_ext) ? w1 : 32'd0;

  // Extract: window of two words, align, keep the top count bits
  assign win     = {r0, r1} << off;
  assign win_hi  = win[63:32];
  assign read_sh = 6'd32 - cnt_q;

  // Append: place value MSB first at the cursor offset
  assign place_sh = 7'd64 - {1'b0, cnt_q} - {2'b0, off};
  assign placed   = {32'd0, value_q} << place_sh;
  assign old_word = (off != '0) ? w0 : 32'd0;
  assign w1_ok    = (word1 < WI_W'(STORE_WORDS));

  always_comb begin
    status_d    = bspe_pkg::STAT_OK;
    read_data_d = 32'd0;
    if (op_q == bspe_pkg::OP_READ) begin
      read_data_d = (cnt_q == '0) ? 32'd0 : (win_hi >> read_sh);
    end else if ((cnt_q < bspe_pkg::CNT_W'(bspe_pkg::WORD_BITS)) &&
                 ((value_q >> cnt_q) != 32'd0)) begin
      status_d = bspe_pkg::STAT_WIDE;
    end else if ((cur_ext + SW'(cnt_q)) > SW'(STORE_BITS)) begin
      status_d = bspe_pkg::STAT_FULL;
    end
  end

  assign do_app = cmd_i.finish && (op_q == bspe_pkg::OP_APPEND) &&
                  (status_d == bspe_pkg::STAT_OK) && (cnt_q != '0);

  // Write back: first word merges, second word starts fresh
  assign we_even    = do_app && (!word0[0] || w1_ok);
  assign we_odd     = do_app && (word0[0] || w1_ok);
  assign even_wdata = word0[0] ? placed[31:0] : (old_word | placed[63:32]);
  assign odd_wdata  = word0[0] ? (old_word | placed[63:32]) : placed[31:0];

  always_ff @(posedge clk_i) begin
    if (we_even) mem_even[even_addr] <= even_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (we_odd) mem_odd[odd_addr] <= odd_wdata;
  end

  // Cursor advance
  assign cursor_d = do_app ? (cursor_q + CUR_W'(cnt_q)) : cursor_q;
  assign cur_new  = SW'(cursor_d);
  assign length_d = cur_new[bspe_pkg::LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else begin
      cursor_q <= cursor_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      read_data_q <= read_data_d;
      length_q    <= length_d;
      status_q    <= status_d;
    end
  end

  assign read_data_o     = read_data_q;
  assign stream_length_o = length_q;
  assign status_o        = status_q;

endmodule

// ===== rtl/bit_stream_pack_and_extract.sv =====
// Top level of the bit stream packer: MSB-first append and random-position read.
//
//   channel | valid      | stall        | word fields
//   --------+------------+--------------+---------------------------------------------
//   in      | in_valid_i | in_stall_o   | op_i, value_i, bit_count_i, position_i
//   out     | out_valid_o| out_stall_i  | read_data_o, stream_length_o, status_o
//
// Each word passes a fetch state, which reads the two adjacent store words from the
// even and odd banks, and a write state, which merges or extracts, writes back and
// loads the result. A new word is taken in the write-back cycle, so a steady stream
// takes each word during the prior write-back while the result register drains.
// Reset clears the cursor and control only; words at or past the cursor read
// as zero, so the store needs no clearing pass and is ready right after reset.
// A stalled result holds the write-back cycle and with it the input side.
module bit_stream_pack_and_extract #(
  parameter int STORE_WORDS = bspe_pkg::STORE_WORDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [31:0]                 value_i,
  input  logic [bspe_pkg::CNT_W-1:0]  bit_count_i,
  input  logic [bspe_pkg::POS_W-1:0]  position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 read_data_o,
  output logic [bspe_pkg::LEN_W-1:0]  stream_length_o,
  output logic [bspe_pkg::STAT_W-1:0] status_o
);

  bspe_pkg::cmd_t cmd;

  // Sequencer
  bspe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Store and bit logic
  bspe_dp #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .value_i         (value_i),
    .bit_count_i     (bit_count_i),
    .position_i      (position_i),
    .read_data_o     (read_data_o),
    .stream_length_o (stream_length_o),
    .status_o        (status_o)
  );

endmodule
